/* design/crcnfe_pkg.sv */
// ----------------------------------------------------------------------------
// crcnfe_pkg
// Shared types, constants and the byte-wide crc update for the nibble encoder.
// ----------------------------------------------------------------------------
package crcnfe_pkg;

    localparam logic [15:0] CRC_POLY      = 16'h8F57;
    localparam logic [6:0]  CHAR_BASE     = 7'd71;
    localparam logic [2:0]  N_BYTE_CHARS  = 3'd2;
    localparam logic [2:0]  N_FRAME_CHARS = 3'd6;

    // one byte held in the input stage, with the crc updated by that byte
    typedef struct packed {
        logic        vld;
        logic [7:0]  data;
        logic        last;
        logic [15:0] crc;
    } t_load;

    // msb first, eight shift steps
    function automatic logic [15:0] crc_byte(input logic [15:0] crc_in,
                                             input logic [7:0]  byte_in);
        logic [15:0] c;
        logic [7:0]  b;
        logic        fb;
        c = crc_in;
        b = byte_in;
        for (int k = 0; k < 8; k++) begin
            fb = b[7] ^ c[15];
            c  = {c[14:0], 1'b0} ^ (fb ? CRC_POLY : 16'h0000);
            b  = {b[6:0], 1'b0};
        end
        return c;
    endfunction

endpackage

/* design/crcnfe_chan_if.sv */
// ----------------------------------------------------------------------------
// crcnfe channel interfaces
// Byte input channel and character output channel, valid/ready handshake.
// ----------------------------------------------------------------------------
interface crcnfe_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] data_byte;
    logic       last_byte;

    modport source (output valid, output data_byte, output last_byte, input ready);
    modport sink   (input valid, input data_byte, input last_byte, output ready);
endinterface

interface crcnfe_out_if;
    logic       valid;
    logic       ready;
    logic [6:0] char_code;
    logic       run_end;
    logic       frame_end;

    modport source (output valid, output char_code, output run_end,
                    output frame_end, input ready);
    modport sink   (input valid, input char_code, input run_end,
                    input frame_end, output ready);
endinterface

/* design/crcnfe_stage.sv */
// ----------------------------------------------------------------------------
// crcnfe_stage
// Input register and running crc accumulator.
// ----------------------------------------------------------------------------
module crcnfe_stage (
    input  logic                i_clk,
    input  logic                i_rst_n,
    crcnfe_in_if.sink           i_in,
    input  logic                i_take,
    output crcnfe_pkg::t_load   o_load
);

    logic        r_vld;
    logic [7:0]  r_data;
    logic        r_last;
    logic [15:0] r_crc;
    logic [15:0] n_crc;

    assign i_in.ready = !r_vld || i_take;

    always_comb begin
        n_crc = crcnfe_pkg::crc_byte(r_crc, r_data);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= 1'b0;
            r_crc <= 16'h0000;
        end else begin
            if (i_in.valid && i_in.ready) begin
                r_vld <= 1'b1;
            end else if (i_take) begin
                r_vld <= 1'b0;
            end
            // crc cleared once the frame's last byte leaves
            if (i_take) begin
                r_crc <= r_last ? 16'h0000 : n_crc;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_in.valid && i_in.ready) begin
            r_data <= i_in.data_byte;
            r_last <= i_in.last_byte;
        end
    end

    assign o_load.vld  = r_vld;
    assign o_load.data = r_data;
    assign o_load.last = r_last;
    assign o_load.crc  = n_crc;

`ifndef SYNTHESIS
    a_take_valid: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_take |-> r_vld)
        else $error("byte taken from empty input stage");
    a_crc_clear: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_take && r_last) |=> (r_crc == 16'h0000))
        else $error("crc not cleared after frame end");
    a_empty_ready: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !r_vld |-> i_in.ready)
        else $error("empty input stage not ready");
`endif

endmodule

/* design/crcnfe_ser.sv */
// ----------------------------------------------------------------------------
// crcnfe_ser
// Result register: holds the nibbles of one byte (and trailer) and sends them
// out one character at a time.
// ----------------------------------------------------------------------------
module crcnfe_ser (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  crcnfe_pkg::t_load   i_load,
    output logic                o_take,
    crcnfe_out_if.source        o_out
);

    logic [2:0]  r_cnt;
    logic [23:0] r_sh;
    logic        r_fin;
    logic        w_pop;

    assign w_pop  = o_out.valid && o_out.ready;
    // load when empty, or reload as the final character goes
    assign o_take = i_load.vld && ((r_cnt == 3'd0) || ((r_cnt == 3'd1) && o_out.ready));

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt <= 3'd0;
        end else if (o_take) begin
            r_cnt <= i_load.last ? crcnfe_pkg::N_FRAME_CHARS : crcnfe_pkg::N_BYTE_CHARS;
        end else if (w_pop) begin
            r_cnt <= r_cnt - 3'd1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_take) begin
            r_sh  <= {i_load.data, i_load.crc};
            r_fin <= i_load.last;
        end else if (w_pop) begin
            r_sh  <= {r_sh[19:0], 4'h0};
        end
    end

    assign o_out.valid     = (r_cnt != 3'd0);
    assign o_out.char_code = crcnfe_pkg::CHAR_BASE + {3'b000, r_sh[23:20]};
    assign o_out.run_end   = (r_cnt == 3'd1);
    assign o_out.frame_end = (r_cnt == 3'd1) && r_fin;

`ifndef SYNTHESIS
    a_cnt_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_cnt <= crcnfe_pkg::N_FRAME_CHARS)
        else $error("character count out of range");
    a_load_cnt: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_take |=> ((r_cnt == crcnfe_pkg::N_BYTE_CHARS) ||
                    (r_cnt == crcnfe_pkg::N_FRAME_CHARS)))
        else $error("bad count after load");
    a_fin_run: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out.frame_end |-> (o_out.run_end && r_fin))
        else $error("frame end without run end");
    a_stall_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out.valid && !o_out.ready) |=> $stable(r_cnt))
        else $error("count moved while stalled");
`endif

endmodule

/* design/crc16_nibble_ascii_frame_encoder.sv */
// ----------------------------------------------------------------------------
// crc16_nibble_ascii_frame_encoder
// Encodes frame bytes as 'G'-based nibble characters with a crc-16 trailer.
// ----------------------------------------------------------------------------
// usage:
//   i_in  : one frame byte per word, last_byte marks the frame's final byte
//   o_out : one character per word, 'G' plus a nibble, high nibble first
//   an ordinary byte gives two characters, run_end on the second
//   a last byte gives its two characters and then the crc-16 (poly 0x8f57,
//   init 0, msb first) as four characters; run_end and frame_end on the sixth
// path: a byte goes from the input register into the character shift
//   register once that register is empty or sends its final character; the
//   crc is worked out combinationally between the two registers
// flow: an ordinary byte gives two characters and a last byte six, which
//   leave the output register at one character per cycle while o_out.ready
//   is high; the next byte waits in the input register meanwhile
// reset: crc cleared, both registers empty
// stall: the output word holds while o_out.ready is low; the input register
//   fills and i_in.ready drops until the shift register frees
// ----------------------------------------------------------------------------
module crc16_nibble_ascii_frame_encoder (
    input  logic            i_clk,
    input  logic            i_rst_n,
    crcnfe_in_if.sink       i_in,
    crcnfe_out_if.source    o_out
);

    crcnfe_pkg::t_load w_load;
    logic              w_take;

    crcnfe_stage u_stage (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (i_in),
        .i_take  (w_take),
        .o_load  (w_load)
    );

    crcnfe_ser u_ser (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_load  (w_load),
        .o_take  (w_take),
        .o_out   (o_out)
    );

endmodule
